/* rtl/core/pbwt_pkg.sv */
package pbwt_pkg;

    localparam int MAX_VARINT_BYTES = 10;
    localparam int LENGTH_BITS      = 32;

    localparam int FIELD_W = 29;
    localparam int WIRE_W  = 3;
    localparam int VALUE_W = 64;
    localparam int SHIFT_W = 4;
    localparam int FIXED_W = 3;

    localparam logic [VALUE_W-1:0] LEN_OVER_MASK =
        ~({VALUE_W{1'b1}} >> (VALUE_W - LENGTH_BITS));

    localparam logic [WIRE_W-1:0] WIRE_VARINT  = 3'd0;
    localparam logic [WIRE_W-1:0] WIRE_FIXED64 = 3'd1;
    localparam logic [WIRE_W-1:0] WIRE_LEN     = 3'd2;
    localparam logic [WIRE_W-1:0] WIRE_FIXED32 = 3'd5;

    typedef enum logic [2:0] {
        TOK_VARINT  = 3'd0,
        TOK_LENGTH  = 3'd1,
        TOK_PAYLOAD = 3'd2,
        TOK_FIXED32 = 3'd3,
        TOK_FIXED64 = 3'd4,
        TOK_ERROR   = 3'd5,
        TOK_END     = 3'd6
    } token_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERLONG  = 2'd1,
        ERR_BAD_WIRE  = 2'd2,
        ERR_TRUNCATED = 2'd3
    } error_code_t;

    typedef struct packed {
        token_kind_t          token_kind;
        logic [FIELD_W-1:0]   field_id;
        logic [WIRE_W-1:0]    wire_kind;
        logic [VALUE_W-1:0]   field_value;
        logic [7:0]           payload_byte;
        error_code_t          error_code;
        logic                 ends_message;
    } token_t;

endpackage

/* rtl/core/pbwt_if.sv */
interface pbwt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       message_end;

    modport source (output valid, output data_byte, output message_end, input ready);
    modport sink (input valid, input data_byte, input message_end, output ready);
endinterface

interface pbwt_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [28:0] field_id;
    logic [2:0]  wire_kind;
    logic [63:0] field_value;
    logic [7:0]  payload_byte;
    logic [1:0]  error_code;
    logic        ends_message;

    modport source (output valid, output token_kind, output field_id, output wire_kind,
                    output field_value, output payload_byte, output error_code,
                    output ends_message, input ready);
    modport sink (input valid, input token_kind, input field_id, input wire_kind,
                  input field_value, input payload_byte, input error_code,
                  input ends_message, output ready);
endinterface

/* rtl/core/pbwt_decode.sv */
module pbwt_decode (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [7:0]      data_byte,
    input  logic            message_end,
    output logic            token_valid,
    output pbwt_pkg::token_t token
);
    import pbwt_pkg::*;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VARINT  = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_FIXED   = 3'd4,
        PH_DISCARD = 3'd5
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [VALUE_W-1:0]     acc_reg, acc_next;
    logic [SHIFT_W-1:0]     shift_reg, shift_next;
    logic [FIELD_W-1:0]     field_reg, field_next;
    logic [WIRE_W-1:0]      wire_reg, wire_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic [FIXED_W-1:0]     fixed_reg, fixed_next;

    logic [6:0]             vshift;
    logic [VALUE_W-1:0]     vacc;
    logic [SHIFT_W-1:0]     vcount;
    logic                   overlong;
    logic                   more;
    logic [VALUE_W-1:0]     facc;
    logic [FIXED_W:0]       fcount;
    logic [FIXED_W:0]       fneed;
    logic [LENGTH_BITS-1:0] left_dec;

    logic                   err;
    error_code_t            err_code;
    logic                   err_known;

    // varint byte merge
    always_comb
    begin
        vshift = 7'(shift_reg) * 7'd7;
        vacc   = acc_reg;
        if (vshift < 7'd64)
        begin
            vacc = acc_reg | (VALUE_W'(data_byte[6:0]) << vshift[5:0]);
        end
        vcount   = shift_reg + SHIFT_W'(1);
        overlong = data_byte[7] && (32'(vcount) >= MAX_VARINT_BYTES);
        more     = data_byte[7] && !overlong;
    end

    // fixed little-endian merge
    assign facc     = acc_reg | (VALUE_W'(data_byte) << {fixed_reg, 3'b000});
    assign fcount   = {1'b0, fixed_reg} + (FIXED_W + 1)'(1);
    assign fneed    = (wire_reg == WIRE_FIXED64) ? (FIXED_W + 1)'(8) : (FIXED_W + 1)'(4);
    assign left_dec = (left_reg != '0) ? left_reg - LENGTH_BITS'(1) : left_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        shift_next  = shift_reg;
        field_next  = field_reg;
        wire_next   = wire_reg;
        left_next   = left_reg;
        fixed_next  = fixed_reg;
        err         = 1'b0;
        err_code    = ERR_NONE;
        err_known   = 1'b1;
        token_valid = 1'b0;
        token       = '0;
        token.field_id     = field_reg;
        token.wire_kind    = wire_reg;
        token.ends_message = message_end;

        case (phase_reg)
            PH_DISCARD:
            begin
                if (message_end)
                begin
                    phase_next  = PH_TAG;
                    acc_next    = '0;
                    shift_next  = '0;
                    fixed_next  = '0;
                    left_next   = '0;
                    token_valid = 1'b1;
                    token.token_kind = TOK_END;
                    token.field_id   = '0;
                    token.wire_kind  = '0;
                end
            end

            PH_VARINT, PH_LEN:
            begin
                acc_next   = vacc;
                shift_next = vcount;
                if (overlong)
                begin
                    err      = 1'b1;
                    err_code = ERR_OVERLONG;
                end
                else if (more)
                begin
                    if (message_end)
                    begin
                        err      = 1'b1;
                        err_code = ERR_TRUNCATED;
                    end
                end
                else if (phase_reg == PH_VARINT)
                begin
                    phase_next  = PH_TAG;
                    acc_next    = '0;
                    shift_next  = '0;
                    fixed_next  = '0;
                    left_next   = '0;
                    token_valid = 1'b1;
                    token.token_kind  = TOK_VARINT;
                    token.field_value = vacc;
                end
                else if ((vacc & LEN_OVER_MASK) != '0)
                begin
                    err      = 1'b1;
                    err_code = ERR_BAD_WIRE;
                end
                else
                begin
                    phase_next = PH_TAG;
                    acc_next   = '0;
                    shift_next = '0;
                    fixed_next = '0;
                    left_next  = '0;
                    if (vacc != '0)
                    begin
                        if (message_end)
                        begin
                            err      = 1'b1;
                            err_code = ERR_TRUNCATED;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                            left_next  = vacc[LENGTH_BITS-1:0];
                        end
                    end
                    token_valid = 1'b1;
                    token.token_kind  = TOK_LENGTH;
                    token.field_value = vacc;
                end
            end

            PH_PAYLOAD:
            begin
                if (left_dec == '0)
                begin
                    phase_next = PH_TAG;
                    acc_next   = '0;
                    shift_next = '0;
                    fixed_next = '0;
                    left_next  = '0;
                end
                else
                begin
                    left_next = left_dec;
                    if (message_end)
                    begin
                        err      = 1'b1;
                        err_code = ERR_TRUNCATED;
                    end
                end
                token_valid = 1'b1;
                token.token_kind   = TOK_PAYLOAD;
                token.payload_byte = data_byte;
            end

            PH_FIXED:
            begin
                acc_next   = facc;
                fixed_next = fcount[FIXED_W-1:0];
                if (fcount >= fneed)
                begin
                    phase_next  = PH_TAG;
                    acc_next    = '0;
                    shift_next  = '0;
                    fixed_next  = '0;
                    left_next   = '0;
                    token_valid = 1'b1;
                    token.token_kind  = (wire_reg == WIRE_FIXED64) ? TOK_FIXED64 : TOK_FIXED32;
                    token.field_value = facc;
                end
                else if (message_end)
                begin
                    err      = 1'b1;
                    err_code = ERR_TRUNCATED;
                end
            end

            default:
            begin
                phase_next = PH_TAG;
                acc_next   = vacc;
                shift_next = vcount;
                if (overlong)
                begin
                    err       = 1'b1;
                    err_code  = ERR_OVERLONG;
                    err_known = 1'b0;
                end
                else if (more)
                begin
                    if (message_end)
                    begin
                        err       = 1'b1;
                        err_code  = ERR_TRUNCATED;
                        err_known = 1'b0;
                    end
                end
                else
                begin
                    field_next = vacc[FIELD_W+2:3];
                    wire_next  = vacc[2:0];
                    acc_next   = '0;
                    shift_next = '0;
                    fixed_next = '0;
                    case (vacc[2:0])
                        WIRE_VARINT:  phase_next = PH_VARINT;
                        WIRE_LEN:     phase_next = PH_LEN;
                        WIRE_FIXED64: phase_next = PH_FIXED;
                        WIRE_FIXED32: phase_next = PH_FIXED;
                        default:
                        begin
                            err      = 1'b1;
                            err_code = ERR_BAD_WIRE;
                        end
                    endcase
                    if (!err && message_end)
                    begin
                        err      = 1'b1;
                        err_code = ERR_TRUNCATED;
                    end
                end
            end
        endcase

        if (err)
        begin
            phase_next  = message_end ? PH_TAG : PH_DISCARD;
            acc_next    = '0;
            shift_next  = '0;
            fixed_next  = '0;
            left_next   = '0;
            token_valid = 1'b1;
            token       = '0;
            token.token_kind   = TOK_ERROR;
            token.field_id     = err_known ? field_next : '0;
            token.wire_kind    = err_known ? wire_next : '0;
            token.error_code   = err_code;
            token.ends_message = message_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            acc_reg   <= '0;
            shift_reg <= '0;
            field_reg <= '0;
            wire_reg  <= '0;
            left_reg  <= '0;
            fixed_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
            field_reg <= field_next;
            wire_reg  <= wire_next;
            left_reg  <= left_next;
            fixed_reg <= fixed_next;
        end
    end

endmodule

/* rtl/core/protobuf_wire_tokenizer.sv */
// protocol-buffer wire tokenizer
// byte_stream: one beat per message byte, message_end set on the last byte
// token_stream: zero or one token beat per byte (varint, length header,
//   payload byte, fixed32, fixed64, error, end after discard)
// a byte sits in an input register, is decoded against the field state
//   and lands in the output register, which drives the token beat
// throughput is one byte per cycle while token_stream does not stall;
//   the single decode step between the two registers updates the field
//   state once per byte; bytes that give no token still pass this step,
//   so they also use up a decode step each
// when token_stream stalls, the output register holds its token and the
//   input register holds one more byte; ready drops only when both are full
// reset empties both registers and returns the decoder to a message start
module protobuf_wire_tokenizer (
    input  logic         clk,
    input  logic         rst_n,
    pbwt_byte_if.sink    byte_stream,
    pbwt_token_if.source token_stream
);
    import pbwt_pkg::*;

    logic       stage_valid_reg, stage_valid_next;
    logic [7:0] stage_byte_reg;
    logic       stage_last_reg;
    logic       out_valid_reg, out_valid_next;
    token_t     out_token_reg;

    logic       advance;
    logic       step;
    logic       res_valid;
    token_t     res_token;

    assign advance = !out_valid_reg || token_stream.ready;
    assign step    = stage_valid_reg && advance;
    assign byte_stream.ready = !stage_valid_reg || advance;

    assign stage_valid_next = byte_stream.ready ? byte_stream.valid : stage_valid_reg;
    assign out_valid_next   = advance ? (step && res_valid) : out_valid_reg;

    pbwt_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (stage_byte_reg),
        .message_end (stage_last_reg),
        .token_valid (res_valid),
        .token       (res_token)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_stream.valid && byte_stream.ready)
        begin
            stage_byte_reg <= byte_stream.data_byte;
            stage_last_reg <= byte_stream.message_end;
        end
        if (step && res_valid)
        begin
            out_token_reg <= res_token;
        end
    end

    assign token_stream.valid        = out_valid_reg;
    assign token_stream.token_kind   = out_token_reg.token_kind;
    assign token_stream.field_id     = out_token_reg.field_id;
    assign token_stream.wire_kind    = out_token_reg.wire_kind;
    assign token_stream.field_value  = out_token_reg.field_value;
    assign token_stream.payload_byte = out_token_reg.payload_byte;
    assign token_stream.error_code   = out_token_reg.error_code;
    assign token_stream.ends_message = out_token_reg.ends_message;

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_stream.ready |-> (stage_valid_reg && out_valid_reg && !token_stream.ready))
        else $error("input stalled without a full pipeline");

    a_error_code_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_token_reg.token_kind == TOK_ERROR)
                           == (out_token_reg.error_code != ERR_NONE)))
        else $error("error code does not match token kind");

    a_end_token_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_token_reg.token_kind == TOK_END) |->
        (out_token_reg.ends_message && out_token_reg.field_id == '0))
        else $error("end token without message end");

    a_payload_only_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_token_reg.token_kind != TOK_PAYLOAD) |->
        (out_token_reg.payload_byte == 8'd0))
        else $error("payload byte set on non-payload token");

    a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
        (!stage_valid_reg && token_stream.ready) |=> !out_valid_reg)
        else $error("token appeared without a byte");

endmodule
